// File: hdl/bped_pkg.sv
// shared types and constants for the button press event detector
// no dependencies
`default_nettype none

package bped_pkg;

  localparam int unsigned CLICK_WINDOW_MS_DEF = 200;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_IDLE_LEVEL    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_MS = 1'd1;

  localparam logic        IDLE_LEVEL_RST    = 1'b1;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd500;

  typedef enum logic [1:0] {
    BTN_IDLE    = 2'd0,
    BTN_PRESSED = 2'd1,
    BTN_LONG    = 2'd2
  } btn_state_e;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic       press_event;
    logic       release_event;
    logic       change_event;
    logic       long_press_first;
    logic       long_press_held;
    logic       double_click_event;
    logic [1:0] button_state;
    logic [7:0] click_count;
  } out_beat_t;

endpackage

`default_nettype wire

// File: hdl/button_press_event_detector.sv
// Button press event detector: one scan beat in, one event beat out. Each beat
// moves through an input register and then an output register, and a new scan
// is taken every cycle while the output side keeps up. The button state, press
// and release times and the double-click counter update as a beat moves from
// the input register to the output register. Time differences wrap modulo
// 2^32; a long press needs a hold strictly longer than long_press_ms.
// depends on bped_pkg
`default_nettype none

module button_press_event_detector #(
  parameter int unsigned CLICK_WINDOW_MS = bped_pkg::CLICK_WINDOW_MS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [bped_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire  [bped_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  bped_pkg::in_beat_t             in_beat_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output bped_pkg::out_beat_t                  out_beat_o
);

  import bped_pkg::*;

  logic        idle_level_q;
  logic [15:0] long_press_ms_q;

  logic       s1_valid_q;
  in_beat_t   s1_beat_q;
  logic       out_valid_q;
  out_beat_t  out_beat_q;

  logic        is_down_q, is_down_d;
  logic        is_long_q, is_long_d;
  logic [31:0] press_time_q, press_time_d;
  logic [31:0] release_time_q, release_time_d;
  logic [7:0]  click_cnt_q, click_cnt_d;
  btn_state_e  state_q, state_d;

  logic        out_ready;
  logic        s1_move;
  logic        in_take;
  logic        active;
  logic        long_hit;
  logic [31:0] held_ms;
  logic [31:0] since_rel_ms;
  logic        in_window;
  out_beat_t   res;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_level_q    <= IDLE_LEVEL_RST;
      long_press_ms_q <= LONG_PRESS_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDLE_LEVEL:    idle_level_q    <= cfg_data_i[0];
        CFG_LONG_PRESS_MS: long_press_ms_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign active   = s1_beat_q.pin_level != idle_level_q;
  assign held_ms  = s1_beat_q.now_ms - press_time_q;
  assign long_hit = held_ms > {16'd0, long_press_ms_q};

  // next state
  always_comb begin
    is_down_d      = is_down_q;
    is_long_d      = is_long_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    state_d        = state_q;
    if (!is_down_q && active) begin
      is_down_d    = 1'b1;
      state_d      = BTN_PRESSED;
      press_time_d = s1_beat_q.now_ms;
    end else if (is_down_q && active && long_hit) begin
      state_d   = BTN_LONG;
      is_long_d = 1'b1;
    end else if (is_down_q && !active) begin
      is_down_d      = 1'b0;
      is_long_d      = 1'b0;
      state_d        = BTN_IDLE;
      release_time_d = s1_beat_q.now_ms;
    end
  end

  assign since_rel_ms = s1_beat_q.now_ms - release_time_q;
  assign in_window    = is_down_d && (since_rel_ms < 32'(CLICK_WINDOW_MS));
  assign click_cnt_d  = in_window ? click_cnt_q + 8'd1 : click_cnt_q;

  // outputs
  always_comb begin
    res                    = '0;
    res.press_event        = !is_down_q && active;
    res.release_event      = is_down_q && !active;
    res.change_event       = res.press_event || res.release_event;
    res.long_press_held    = is_down_q && active && long_hit;
    res.long_press_first   = res.long_press_held && !is_long_q;
    res.double_click_event = in_window;
    res.button_state       = state_d;
    res.click_count        = click_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_down_q      <= 1'b0;
      is_long_q      <= 1'b0;
      press_time_q   <= '0;
      release_time_q <= '0;
      click_cnt_q    <= '0;
      state_q        <= BTN_IDLE;
    end else if (s1_move) begin
      is_down_q      <= is_down_d;
      is_long_q      <= is_long_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      click_cnt_q    <= click_cnt_d;
      state_q        <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_beat_q <= in_beat_i;
    end
    if (s1_move) begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

// File: hdl/bped_checker.sv
// port-level checks for the button press event detector, bound to the top level
// depends on bped_pkg and button_press_event_detector
`default_nettype none

module bped_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire bped_pkg::out_beat_t out_beat_o
);

  import bped_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out beat dropped while stalled");

  a_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.change_event ==
                     (out_beat_o.press_event || out_beat_o.release_event)))
    else $error("change flag mismatch");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_beat_o.press_event && out_beat_o.release_event)
                    && !(out_beat_o.press_event && out_beat_o.long_press_held))
    else $error("conflicting events in one beat");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.long_press_first |->
      out_beat_o.long_press_held && (out_beat_o.button_state == BTN_LONG))
    else $error("first long press without held");

  a_press_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.press_event |->
      out_beat_o.button_state == BTN_PRESSED)
    else $error("press without pressed state");

endmodule

bind button_press_event_detector bped_checker u_bped_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
